// ===== src/xxhash32_stream_hasher_core_assert.svh =====
// ----------------------------------------------------------------------------
// xxHash32 stream hasher assertion macros
// Concurrent check wrappers used by the core RTL file.
// ----------------------------------------------------------------------------
`ifndef XXHASH32_STREAM_HASHER_CORE_ASSERT_SVH
`define XXHASH32_STREAM_HASHER_CORE_ASSERT_SVH

// same-cycle implication
`define XXH_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define XXH_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/xxh_pkg.sv =====
// ----------------------------------------------------------------------------
// xxh_pkg
// Constants, microcode word format and helper functions of the xxHash32 core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xxh_pkg;

    localparam logic [31:0] P1 = 32'h9E37_79B1;
    localparam logic [31:0] P2 = 32'h85EB_CA77;
    localparam logic [31:0] P3 = 32'hC2B2_AE3D;
    localparam logic [31:0] P4 = 32'h27D4_EB2F;
    localparam logic [31:0] P5 = 32'h1656_67B1;

    localparam int PC_W  = 5;
    localparam int IDX_W = 3;

    // microprogram addresses
    localparam logic [PC_W-1:0] ADDR_IDLE        = 5'd0;
    localparam logic [PC_W-1:0] ADDR_STRIPE_MUL  = 5'd1;
    localparam logic [PC_W-1:0] ADDR_STRIPE_RND  = 5'd2;
    localparam logic [PC_W-1:0] ADDR_STRIPE_WR   = 5'd3;
    localparam logic [PC_W-1:0] ADDR_STRIPE_END  = 5'd4;
    localparam logic [PC_W-1:0] ADDR_FIN_SEED    = 5'd5;
    localparam logic [PC_W-1:0] ADDR_FOLD0       = 5'd6;
    localparam logic [PC_W-1:0] ADDR_FOLD1       = 5'd7;
    localparam logic [PC_W-1:0] ADDR_FOLD2       = 5'd8;
    localparam logic [PC_W-1:0] ADDR_FOLD3       = 5'd9;
    localparam logic [PC_W-1:0] ADDR_ADD_LEN     = 5'd10;
    localparam logic [PC_W-1:0] ADDR_WORD_MUL    = 5'd11;
    localparam logic [PC_W-1:0] ADDR_WORD_RND    = 5'd12;
    localparam logic [PC_W-1:0] ADDR_WORD_WR     = 5'd13;
    localparam logic [PC_W-1:0] ADDR_BYTE_CLR    = 5'd14;
    localparam logic [PC_W-1:0] ADDR_BYTE_MUL    = 5'd15;
    localparam logic [PC_W-1:0] ADDR_BYTE_RND    = 5'd16;
    localparam logic [PC_W-1:0] ADDR_BYTE_WR     = 5'd17;
    localparam logic [PC_W-1:0] ADDR_AVL_XSH     = 5'd18;
    localparam logic [PC_W-1:0] ADDR_AVL_MUL2    = 5'd19;
    localparam logic [PC_W-1:0] ADDR_AVL_XSH2    = 5'd20;
    localparam logic [PC_W-1:0] ADDR_AVL_MUL3    = 5'd21;
    localparam logic [PC_W-1:0] ADDR_AVL_XSH3    = 5'd22;
    localparam logic [PC_W-1:0] ADDR_EMIT        = 5'd23;

    typedef enum logic [1:0] {
        M_NONE = 2'd0,
        M_X    = 2'd1,
        M_RND  = 2'd2
    } mul_op_t;

    typedef enum logic [1:0] {
        X_WORDS = 2'd0,
        X_BYTE  = 2'd1,
        X_H     = 2'd2
    } xsel_t;

    typedef enum logic [2:0] {
        K_P1 = 3'd0,
        K_P2 = 3'd1,
        K_P3 = 3'd2,
        K_P4 = 3'd3,
        K_P5 = 3'd4
    } ksel_t;

    typedef enum logic [2:0] {
        H_KEEP     = 3'd0,
        H_SEED5    = 3'd1,
        H_FOLD_SET = 3'd2,
        H_FOLD_ADD = 3'd3,
        H_ADD_LEN  = 3'd4,
        H_PROD     = 3'd5,
        H_XSH      = 3'd6,
        H_PROD_XSH = 3'd7
    } hop_t;

    typedef enum logic [1:0] {
        I_KEEP = 2'd0,
        I_CLR  = 2'd1,
        I_INC  = 2'd2
    } idx_op_t;

    typedef enum logic [3:0] {
        J_IDLE      = 4'd0,
        J_NEXT      = 4'd1,
        J_GOTO      = 4'd2,
        J_NOSEEN    = 4'd3,
        J_PEND_DONE = 4'd4,
        J_TAIL_DONE = 4'd5,
        J_LANE_LOOP = 4'd6,
        J_FIN       = 4'd7,
        J_EMIT      = 4'd8
    } jmp_t;

    typedef struct packed {
        mul_op_t         mul_op;
        xsel_t           x_sel;
        logic            acc_lane;
        ksel_t           k_sel;
        logic [4:0]      rot;
        hop_t            h_op;
        logic            lane_idx;
        logic [1:0]      lane_fix;
        logic            lane_wr;
        logic            stripe_done;
        idx_op_t         idx_op;
        jmp_t            jmp;
        logic [PC_W-1:0] target;
    } ucode_t;

    localparam ucode_t UC_NOP = '{
        mul_op: M_NONE, x_sel: X_WORDS, acc_lane: 1'b0, k_sel: K_P1, rot: 5'd0,
        h_op: H_KEEP, lane_idx: 1'b0, lane_fix: 2'd0, lane_wr: 1'b0,
        stripe_done: 1'b0, idx_op: I_KEEP, jmp: J_NEXT, target: ADDR_IDLE
    };

    typedef struct packed {
        logic        take;
        logic        store;
        logic [31:0] word;
        logic [2:0]  n;
    } item_t;

    typedef struct packed {
        logic       seen;
        logic [1:0] pcnt;
        logic [1:0] tail_n;
    } dp_stat_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] r);
        logic [63:0] t;
        t = {v, v} << r;
        return t[63:32];
    endfunction

    function automatic logic [31:0] kval(input ksel_t k);
        logic [31:0] v;
        unique case (k)
            K_P1:    v = P1;
            K_P2:    v = P2;
            K_P3:    v = P3;
            K_P4:    v = P4;
            K_P5:    v = P5;
            default: v = P1;
        endcase
        return v;
    endfunction

endpackage

// ===== src/xxh_ucode_rom.sv =====
// ----------------------------------------------------------------------------
// xxh_ucode_rom
// Microprogram store: one control word per step address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xxh_ucode_rom (
    input  logic [xxh_pkg::PC_W-1:0] pc,
    output xxh_pkg::ucode_t          uc
);
    import xxh_pkg::*;

    always_comb begin
        uc = UC_NOP;
        unique case (pc)
            ADDR_IDLE: begin
                uc.jmp = J_IDLE;
            end
            // lane = rotl(lane + w * P2, 13) * P1
            ADDR_STRIPE_MUL: begin
                uc.mul_op = M_X;
                uc.x_sel  = X_WORDS;
                uc.k_sel  = K_P2;
            end
            ADDR_STRIPE_RND: begin
                uc.mul_op   = M_RND;
                uc.acc_lane = 1'b1;
                uc.lane_idx = 1'b1;
                uc.rot      = 5'd13;
                uc.k_sel    = K_P1;
            end
            ADDR_STRIPE_WR: begin
                uc.lane_wr  = 1'b1;
                uc.lane_idx = 1'b1;
                uc.idx_op   = I_INC;
                uc.jmp      = J_LANE_LOOP;
                uc.target   = ADDR_STRIPE_MUL;
            end
            ADDR_STRIPE_END: begin
                uc.stripe_done = 1'b1;
                uc.jmp         = J_FIN;
                uc.target      = ADDR_FIN_SEED;
            end
            ADDR_FIN_SEED: begin
                uc.h_op   = H_SEED5;
                uc.jmp    = J_NOSEEN;
                uc.target = ADDR_ADD_LEN;
            end
            ADDR_FOLD0: begin
                uc.h_op     = H_FOLD_SET;
                uc.lane_fix = 2'd0;
                uc.rot      = 5'd1;
            end
            ADDR_FOLD1: begin
                uc.h_op     = H_FOLD_ADD;
                uc.lane_fix = 2'd1;
                uc.rot      = 5'd7;
            end
            ADDR_FOLD2: begin
                uc.h_op     = H_FOLD_ADD;
                uc.lane_fix = 2'd2;
                uc.rot      = 5'd12;
            end
            ADDR_FOLD3: begin
                uc.h_op     = H_FOLD_ADD;
                uc.lane_fix = 2'd3;
                uc.rot      = 5'd18;
            end
            ADDR_ADD_LEN: begin
                uc.h_op   = H_ADD_LEN;
                uc.idx_op = I_CLR;
            end
            // buffered words: h = rotl(h + w * P3, 17) * P4
            ADDR_WORD_MUL: begin
                uc.mul_op = M_X;
                uc.x_sel  = X_WORDS;
                uc.k_sel  = K_P3;
                uc.jmp    = J_PEND_DONE;
                uc.target = ADDR_BYTE_CLR;
            end
            ADDR_WORD_RND: begin
                uc.mul_op = M_RND;
                uc.rot    = 5'd17;
                uc.k_sel  = K_P4;
            end
            ADDR_WORD_WR: begin
                uc.h_op   = H_PROD;
                uc.idx_op = I_INC;
                uc.jmp    = J_GOTO;
                uc.target = ADDR_WORD_MUL;
            end
            ADDR_BYTE_CLR: begin
                uc.idx_op = I_CLR;
            end
            // tail bytes: h = rotl(h + b * P5, 11) * P1
            ADDR_BYTE_MUL: begin
                uc.mul_op = M_X;
                uc.x_sel  = X_BYTE;
                uc.k_sel  = K_P5;
                uc.jmp    = J_TAIL_DONE;
                uc.target = ADDR_AVL_XSH;
            end
            ADDR_BYTE_RND: begin
                uc.mul_op = M_RND;
                uc.rot    = 5'd11;
                uc.k_sel  = K_P1;
            end
            ADDR_BYTE_WR: begin
                uc.h_op   = H_PROD;
                uc.idx_op = I_INC;
                uc.jmp    = J_GOTO;
                uc.target = ADDR_BYTE_MUL;
            end
            ADDR_AVL_XSH: begin
                uc.h_op = H_XSH;
                uc.rot  = 5'd15;
            end
            ADDR_AVL_MUL2: begin
                uc.mul_op = M_X;
                uc.x_sel  = X_H;
                uc.k_sel  = K_P2;
            end
            ADDR_AVL_XSH2: begin
                uc.h_op = H_PROD_XSH;
                uc.rot  = 5'd13;
            end
            ADDR_AVL_MUL3: begin
                uc.mul_op = M_X;
                uc.x_sel  = X_H;
                uc.k_sel  = K_P3;
            end
            ADDR_AVL_XSH3: begin
                uc.h_op = H_PROD_XSH;
                uc.rot  = 5'd16;
            end
            ADDR_EMIT: begin
                uc.jmp = J_EMIT;
            end
            default: begin
                uc = UC_NOP;
            end
        endcase
    end

endmodule

// ===== src/xxh_datapath.sv =====
// ----------------------------------------------------------------------------
// xxh_datapath
// Lane accumulators, word buffer, length and hash registers around one
// shared 32x32 multiplier with registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xxh_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  xxh_pkg::ucode_t           uc,
    input  logic [xxh_pkg::IDX_W-1:0] idx,
    input  xxh_pkg::item_t            item,
    input  logic                      restart,
    input  logic                      cfg_wr_en,
    input  logic [31:0]               cfg_wr_data,
    output xxh_pkg::dp_stat_t         stat,
    output logic [31:0]               hash
);
    import xxh_pkg::*;

    logic [31:0] seed_reg, seed_next;
    logic [31:0] lane_reg [4];
    logic [31:0] lane_next [4];
    logic [31:0] pend_reg [3];
    logic [31:0] pend_next [3];
    logic [1:0]  pcnt_reg, pcnt_next;
    logic [31:0] len_reg, len_next;
    logic        seen_reg, seen_next;
    logic [31:0] word_reg, word_next;
    logic [1:0]  tail_reg, tail_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] prod_reg, prod_next;

    logic        new_msg;
    logic [1:0]  lsel;
    logic [31:0] lane_q;
    logic [31:0] x_word;
    logic [7:0]  x_byte;
    logic [31:0] x_val;
    logic [31:0] acc_val;
    logic [31:0] mul_a;
    logic [31:0] mul_lo;

    assign new_msg = restart || cfg_wr_en;
    assign lsel    = uc.lane_idx ? idx[1:0] : uc.lane_fix;
    assign lane_q  = lane_reg[lsel];

    always_comb begin
        case (idx[1:0])
            2'd0:    x_word = pend_reg[0];
            2'd1:    x_word = pend_reg[1];
            2'd2:    x_word = pend_reg[2];
            default: x_word = word_reg;
        endcase
    end

    assign x_byte = 8'(word_reg >> {idx[1:0], 3'b000});

    always_comb begin
        unique case (uc.x_sel)
            X_WORDS: x_val = x_word;
            X_BYTE:  x_val = {24'd0, x_byte};
            X_H:     x_val = h_reg;
            default: x_val = x_word;
        endcase
    end

    assign acc_val = uc.acc_lane ? lane_q : h_reg;
    assign mul_a   = (uc.mul_op == M_RND) ? rotl32(acc_val + prod_reg, uc.rot) : x_val;
    assign mul_lo  = mul_a * kval(uc.k_sel);

    always_comb begin
        prod_next = (uc.mul_op == M_NONE) ? prod_reg : mul_lo;
    end

    always_comb begin
        unique case (uc.h_op)
            H_KEEP:     h_next = h_reg;
            H_SEED5:    h_next = seed_reg + P5;
            H_FOLD_SET: h_next = rotl32(lane_q, uc.rot);
            H_FOLD_ADD: h_next = h_reg + rotl32(lane_q, uc.rot);
            H_ADD_LEN:  h_next = h_reg + len_reg;
            H_PROD:     h_next = prod_reg;
            H_XSH:      h_next = h_reg ^ (h_reg >> uc.rot);
            H_PROD_XSH: h_next = prod_reg ^ (prod_reg >> uc.rot);
            default:    h_next = h_reg;
        endcase
    end

    always_comb begin
        seed_next = cfg_wr_en ? cfg_wr_data : seed_reg;
        lane_next = lane_reg;
        pend_next = pend_reg;
        pcnt_next = pcnt_reg;
        len_next  = len_reg;
        seen_next = seen_reg;
        word_next = word_reg;
        tail_next = tail_reg;
        if (new_msg) begin
            lane_next[0] = seed_next + P1 + P2;
            lane_next[1] = seed_next + P2;
            lane_next[2] = seed_next;
            lane_next[3] = seed_next - P1;
            pcnt_next    = 2'd0;
            len_next     = 32'd0;
            seen_next    = 1'b0;
        end else begin
            if (uc.lane_wr) begin
                lane_next[lsel] = prod_reg;
            end
            if (uc.stripe_done) begin
                pcnt_next = 2'd0;
                seen_next = 1'b1;
            end
            if (item.take) begin
                len_next  = len_reg + 32'(item.n);
                word_next = item.word;
                tail_next = item.n[2] ? 2'd0 : item.n[1:0];
            end
            if (item.store) begin
                pend_next[pcnt_reg] = item.word;
                pcnt_next           = pcnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg    <= 32'd0;
            lane_reg[0] <= P1 + P2;
            lane_reg[1] <= P2;
            lane_reg[2] <= 32'd0;
            lane_reg[3] <= 32'd0 - P1;
            pcnt_reg    <= 2'd0;
            len_reg     <= 32'd0;
            seen_reg    <= 1'b0;
        end else begin
            seed_reg <= seed_next;
            lane_reg <= lane_next;
            pcnt_reg <= pcnt_next;
            len_reg  <= len_next;
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        word_reg <= word_next;
        tail_reg <= tail_next;
        h_reg    <= h_next;
        prod_reg <= prod_next;
    end

    assign stat.seen   = seen_reg;
    assign stat.pcnt   = pcnt_reg;
    assign stat.tail_n = tail_reg;
    assign hash        = h_reg;

endmodule

// ===== src/xxhash32_stream_hasher_core.sv =====
// ----------------------------------------------------------------------------
// xxhash32_stream_hasher_core
// Streaming xxHash32 of a little-endian word stream, microcoded control.
// ----------------------------------------------------------------------------
// A word that does not complete a 16-byte stripe is held in the word buffer; a
// word that completes one runs the four lane rounds one after another through
// the single shared multiplier (three steps per lane). The last beat starts
// the finalization microprogram on the same multiplier, after the stripe
// rounds when that beat itself completes a stripe; it folds in the lanes if a
// stripe was absorbed, then the buffered words (0..3) and the tail bytes
// (0..3). Input is accepted only while the sequencer is at its idle step; a
// finished hash waits in the output register while the next message streams
// in. Writing the seed restarts the message state.
`timescale 1ns / 1ps
`include "xxhash32_stream_hasher_core_assert.svh"

module xxhash32_stream_hasher_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // [31:0] word, [34:32] byte_count, zero pad
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata     // [31:0] hash
);
    import xxh_pkg::*;

    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             fin_reg, fin_next;
    logic             m_valid_reg, m_valid_next;
    logic [31:0]      m_data_reg, m_data_next;

    ucode_t   uc;
    item_t    item;
    dp_stat_t stat;
    logic [31:0] hash;

    logic [2:0]  n_raw, n_cl;
    logic        full_word, ignore, fin, accept, stripe_go;
    logic        out_busy, emit_fire, emit_stall;
    logic [PC_W-1:0] pc_inc;

    xxh_ucode_rom u_rom (
        .pc (pc_reg),
        .uc (uc)
    );

    xxh_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .uc          (uc),
        .idx         (idx_reg),
        .item        (item),
        .restart     (emit_fire),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stat        (stat),
        .hash        (hash)
    );

    assign s_tready  = (pc_reg == ADDR_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign n_raw     = s_tdata[34:32];
    assign n_cl      = (n_raw > 3'd4) ? 3'd4 : n_raw;
    assign full_word = (n_cl == 3'd4);
    assign ignore    = (n_cl == 3'd0) && !s_tlast;
    assign fin       = s_tlast || !full_word;
    assign stripe_go = accept && !ignore && full_word && (stat.pcnt == 2'd3);

    assign item.take  = accept && !ignore;
    assign item.store = accept && full_word && (stat.pcnt != 2'd3);
    assign item.word  = s_tdata[31:0];
    assign item.n     = n_cl;

    assign out_busy   = m_valid_reg && !m_tready;
    assign emit_fire  = (uc.jmp == J_EMIT) && !out_busy;
    assign emit_stall = (uc.jmp == J_EMIT) && out_busy;
    assign pc_inc     = pc_reg + PC_W'(1);

    always_comb begin
        pc_next  = pc_reg;
        idx_next = idx_reg;
        fin_next = fin_reg;
        unique case (uc.idx_op)
            I_CLR:   idx_next = '0;
            I_INC:   idx_next = idx_reg + IDX_W'(1);
            default: idx_next = idx_reg;
        endcase
        if (cfg_wr_en) begin
            pc_next = ADDR_IDLE;
        end else begin
            unique case (uc.jmp)
                J_IDLE: begin
                    if (item.take) begin
                        idx_next = '0;
                        fin_next = fin;
                        if (stripe_go) begin
                            pc_next = ADDR_STRIPE_MUL;
                        end else if (fin) begin
                            pc_next = ADDR_FIN_SEED;
                        end
                    end
                end
                J_NEXT:      pc_next = pc_inc;
                J_GOTO:      pc_next = uc.target;
                J_NOSEEN:    pc_next = stat.seen ? pc_inc : uc.target;
                J_PEND_DONE: pc_next = (idx_reg >= IDX_W'(stat.pcnt)) ? uc.target : pc_inc;
                J_TAIL_DONE: pc_next = (idx_reg >= IDX_W'(stat.tail_n)) ? uc.target : pc_inc;
                J_LANE_LOOP: pc_next = (idx_reg[1:0] != 2'd3) ? uc.target : pc_inc;
                J_FIN:       pc_next = fin_reg ? uc.target : ADDR_IDLE;
                J_EMIT:      pc_next = out_busy ? pc_reg : ADDR_IDLE;
                default:     pc_next = ADDR_IDLE;
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (emit_fire) begin
            m_valid_next = 1'b1;
            m_data_next  = hash;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= ADDR_IDLE;
            idx_reg     <= '0;
            fin_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            idx_reg     <= idx_next;
            fin_reg     <= fin_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `XXH_ASSERT_NEXT(a_emit_loads, aclk, aresetn, emit_fire, m_valid_reg && s_tready, "emit lost")
    `XXH_ASSERT_NEXT(a_emit_holds, aclk, aresetn, emit_stall, pc_reg == ADDR_EMIT, "emit moved")
    `XXH_ASSERT_NEXT(a_stripe_go, aclk, aresetn, stripe_go, pc_reg == ADDR_STRIPE_MUL, "no stripe")
    `XXH_ASSERT_NEXT(a_cfg_restart, aclk, aresetn, cfg_wr_en, !stat.seen && stat.pcnt == 2'd0, "cfg")

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: xxHash32 stream hasher core testbench
// Directed messages cover lengths around the 16-byte stripe, count encodings
// and seed changes; then random messages stream through with random gaps on
// both sides. Every hash beat is checked against a built-in xxHash32 model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam logic [31:0] PRIME1 = 32'h9E37_79B1;
    localparam logic [31:0] PRIME2 = 32'h85EB_CA77;
    localparam logic [31:0] PRIME3 = 32'hC2B2_AE3D;
    localparam logic [31:0] PRIME4 = 32'h27D4_EB2F;
    localparam logic [31:0] PRIME5 = 32'h1656_67B1;
    localparam int          QUIET_CYCLES = 40;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;       // [31:0] word, [34:32] byte_count, zero pad
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;       // [31:0] hash

    // hash model state
    logic [31:0] hash_seed;
    logic [31:0] lane[4];
    logic [31:0] held_words[3];
    int          held_count;
    logic [31:0] msg_bytes;
    logic        stripe_done;

    logic [31:0] expected_hashes[$];
    logic [31:0] want_hash;
    int          mismatch_count;
    int          hashes_checked;
    int          data_beats;
    int          seed_writes;
    int          src_gap_max;
    int          sink_gap_max;

    xxhash32_stream_hasher_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("timeout with %0d hashes outstanding", expected_hashes.size());
        $display("[xxhash32_stream_hasher_core] ERROR");
        $finish;
    end

    function automatic logic [31:0] rol(input logic [31:0] v, input int r);
        return (v << r) | (v >> (32 - r));
    endfunction

    function automatic logic [31:0] lane_round(input logic [31:0] acc, input logic [31:0] w);
        return rol(acc + w * PRIME2, 13) * PRIME1;
    endfunction

    function automatic void restart_message();
        lane[0] = hash_seed + PRIME1 + PRIME2;
        lane[1] = hash_seed + PRIME2;
        lane[2] = hash_seed;
        lane[3] = hash_seed - PRIME1;
        held_count  = 0;
        msg_bytes   = '0;
        stripe_done = 1'b0;
    endfunction

    function automatic void absorb_word(input logic [31:0] w);
        if (held_count == 3) begin
            lane[0] = lane_round(lane[0], held_words[0]);
            lane[1] = lane_round(lane[1], held_words[1]);
            lane[2] = lane_round(lane[2], held_words[2]);
            lane[3] = lane_round(lane[3], w);
            held_count  = 0;
            stripe_done = 1'b1;
        end else begin
            held_words[held_count] = w;
            held_count++;
        end
    endfunction

    function automatic logic [31:0] final_hash(input logic [31:0] tail, input int tail_bytes);
        logic [31:0] h;
        logic [31:0] b;
        if (stripe_done)
            h = rol(lane[0], 1) + rol(lane[1], 7) + rol(lane[2], 12) + rol(lane[3], 18);
        else
            h = hash_seed + PRIME5;
        h = h + msg_bytes;
        for (int i = 0; i < held_count; i++)
            h = rol(h + held_words[i] * PRIME3, 17) * PRIME4;
        for (int i = 0; i < tail_bytes; i++) begin
            b = (tail >> (8 * i)) & 32'hFF;
            h = rol(h + b * PRIME5, 11) * PRIME1;
        end
        h = h ^ (h >> 15);
        h = h * PRIME2;
        h = h ^ (h >> 13);
        h = h * PRIME3;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic void predict_beat(input logic [31:0] w, input logic [2:0] cnt,
                                         input logic is_last);
        int  n;
        logic fin;
        n   = (cnt > 3'd4) ? 4 : int'(cnt);
        fin = is_last;
        if (n == 0 && !fin)
            return;
        if (n < 4)
            fin = 1'b1;
        msg_bytes = msg_bytes + n;
        if (n == 4)
            absorb_word(w);
        if (fin) begin
            expected_hashes.push_back(final_hash(w, (n < 4) ? n : 0));
            restart_message();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s, got %h expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_hashes.size() == 0) begin
                report_mismatch("hash beat with no message pending", m_tdata, 32'h0);
            end else begin
                want_hash = expected_hashes.pop_front();
                hashes_checked++;
                if (m_tdata !== want_hash)
                    report_mismatch("hash", m_tdata, want_hash);
            end
        end
    end

    // result side back-pressure
    initial begin
        int gap;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = $urandom_range(0, sink_gap_max);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_beat(input logic [31:0] w, input logic [2:0] cnt, input logic is_last);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, cnt, w};
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        predict_beat(w, cnt, is_last);
        if (!(cnt == 3'd0 && !is_last))
            data_beats++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_hashes.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        hash_seed = value;
        restart_message();
        seed_writes++;
    endtask

    // nfull full words, then tail bytes; random noise and end styles
    task automatic send_message(input int nfull, input int tail);
        logic       end_full;
        logic [2:0] cnt;
        logic       fin;
        end_full = 1'($urandom_range(0, 1));
        for (int i = 0; i < nfull; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_beat($urandom, 3'd0, 1'b0);
            cnt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'd4;
            fin = (i == nfull - 1) && tail == 0 && end_full;
            send_beat($urandom, cnt, fin);
        end
        if (tail > 0)
            send_beat($urandom, 3'(tail), $urandom_range(0, 7) != 0);
        else if (!end_full || nfull == 0)
            send_beat($urandom, 3'd0, 1'b1);
    endtask

    task automatic test_message_lengths();
        src_gap_max  = 3;
        sink_gap_max = 3;
        send_beat($urandom, 3'd0, 1'b1);
        send_beat(32'h0000_00A5, 3'd1, 1'b1);
        send_beat(32'hFFFF_FFFF, 3'd3, 1'b1);
        send_beat(32'hFFFF_FFFF, 3'd4, 1'b1);
        send_beat(32'h0000_0000, 3'd4, 1'b0);
        send_beat(32'hFFFF_FFFF, 3'd4, 1'b0);
        send_beat(32'h8000_0001, 3'd4, 1'b0);
        send_beat(32'h7FFF_FFFE, 3'd4, 1'b1);
        for (int i = 0; i < 4; i++)
            send_beat($urandom, 3'd4, 1'b0);
        send_beat($urandom, 3'd3, 1'b1);
    endtask

    task automatic test_count_encodings();
        src_gap_max  = 15;
        sink_gap_max = 15;
        send_beat($urandom, 3'd5, 1'b0);
        send_beat($urandom, 3'd6, 1'b0);
        send_beat($urandom, 3'd7, 1'b1);
        send_beat($urandom, 3'd4, 1'b0);
        send_beat($urandom, 3'd0, 1'b0);
        send_beat($urandom, 3'd4, 1'b1);
        send_beat($urandom, 3'd2, 1'b0);
        for (int i = 0; i < 4; i++)
            send_beat($urandom, 3'd4, 1'b0);
        send_beat($urandom, 3'd0, 1'b1);
    endtask

    task automatic test_seed_settings();
        write_seed(32'hFFFF_FFFF);
        send_beat($urandom, 3'd0, 1'b1);
        send_message(9, 1);
        write_seed(32'h8000_0000);
        send_message(4, 0);
        write_seed(32'h0000_0000);
        send_message(2, 2);
    endtask

    task automatic test_seed_abandon();
        write_seed($urandom);
        for (int i = 0; i < 6; i++)
            send_beat($urandom, 3'd4, 1'b0);
        write_seed($urandom);
        send_message(3, 0);
    endtask

    task automatic test_random_stream();
        int target;
        int nfull;
        for (int phase = 0; phase < 4; phase++) begin
            src_gap_max  = (phase == 1 || phase == 2) ? 0 : 15;
            sink_gap_max = (phase == 1 || phase == 3) ? 0 : 15;
            if (phase > 0)
                write_seed($urandom);
            target = data_beats + 80;
            while (data_beats < target) begin
                nfull = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 8)
                                                    : $urandom_range(9, 40);
                send_message(nfull, $urandom_range(0, 3));
            end
        end
    endtask

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        mismatch_count = 0;
        hashes_checked = 0;
        data_beats     = 0;
        seed_writes    = 0;
        src_gap_max    = 0;
        sink_gap_max   = 0;
        hash_seed      = '0;
        restart_message();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_message_lengths();
        test_count_encodings();
        test_seed_settings();
        test_seed_abandon();
        test_random_stream();
        wait_drained();

        $display("hashed %0d messages from %0d data beats", hashes_checked, data_beats);
        $display("%0d seed writes, %0d mismatches", seed_writes, mismatch_count);
        if (mismatch_count == 0)
            $display("[xxhash32_stream_hasher_core] OK");
        else
            $display("[xxhash32_stream_hasher_core] ERROR");
        $finish;
    end

endmodule
